// ===== sv/bcdec_pkg.sv =====
// bcdec_pkg: shared types, format codes and palette helpers for the BC1..BC5 decoder.
// No dependencies.
package bcdec_pkg;

  localparam int unsigned FmtW = 3;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [FmtW-1:0] {
    FMT_BC1 = 3'd0,
    FMT_BC2 = 3'd1,
    FMT_BC3 = 3'd2,
    FMT_BC4 = 3'd3,
    FMT_BC5 = 3'd4
  } fmt_e;

  // Classified block handed from front to back.
  typedef struct packed {
    fmt_e        fmt;
    logic [63:0] lo;
    logic [63:0] hi;
  } blk_t;

  // Per-block decoded palettes, registered in the back end.
  typedef struct packed {
    logic [3:0][31:0] cpal;   // colour palette, RGBA packed
    logic [7:0][7:0]  apal;   // channel palette from low word
    logic [7:0][7:0]  gpal;   // channel palette from high word
    logic [47:0]      aidx;   // 3-bit indices from low word
    logic [47:0]      gidx;   // 3-bit indices from high word
    logic [31:0]      cidx;   // 2-bit colour indices
    logic [63:0]      lo;     // explicit BC2 alpha nibbles
    fmt_e             fmt;
  } pal_t;

  // c*255/31 = 8c + floor(7c/31); 7c/31 by reciprocal 265/2^13, exact for 7c < 356
  function automatic logic [7:0] exp5(input logic [4:0] c);
    logic [7:0]  y;
    logic [16:0] q;
    y = 8'(c) * 8'd7;
    q = 17'(y) * 17'd265;
    return {c, 3'b000} + 8'(q >> 13);
  endfunction

  // c*255/63 = 4c + floor(c/21); c/21 is at most 3, taken by compares
  function automatic logic [7:0] exp6(input logic [5:0] c);
    return {c, 2'b00} + 8'(c >= 6'd21) + 8'(c >= 6'd42) + 8'(c >= 6'd63);
  endfunction

  function automatic logic [7:0] div3(input logic [9:0] v);
    logic [19:0] p;
    p = 20'(v) * 20'd683;   // exact for v < 1024 with the shift below
    return 8'(p >> 11);
  endfunction

  // /7 by 2341/2^14 (exact below 5461), /5 by 1639/2^13 (exact below 2730)
  function automatic logic [7:0][7:0] chan_pal(input logic [15:0] w);
    logic [7:0][7:0] pal;
    logic [7:0]      v0;
    logic [7:0]      v1;
    logic [10:0]     s;
    logic [22:0]     m;
    v0 = w[7:0];
    v1 = w[15:8];
    pal[0] = v0;
    pal[1] = v1;
    for (int i = 1; i <= 6; i++) begin
      if (v0 > v1) begin
        s = 11'(7 - i) * 11'(v0) + 11'(i) * 11'(v1);
        m = 23'(s) * 23'd2341;
        pal[i+1] = 8'(m >> 14);
      end else if (i <= 4) begin
        s = 11'(5 - i) * 11'(v0) + 11'(i) * 11'(v1);
        m = 23'(s) * 23'd1639;
        pal[i+1] = 8'(m >> 13);
      end else begin
        pal[i+1] = (i == 5) ? 8'd0 : 8'd255;
      end
    end
    return pal;
  endfunction

  function automatic logic [3:0][31:0] color_pal(input logic [31:0] w, input logic three_ok);
    logic [3:0][31:0] pal;
    logic [2:0][7:0]  e0;
    logic [2:0][7:0]  e1;
    logic [2:0][7:0]  p2;
    logic [2:0][7:0]  p3;
    logic [8:0]       h;
    e0[0] = exp5(w[15:11]); e0[1] = exp6(w[10:5]);  e0[2] = exp5(w[4:0]);
    e1[0] = exp5(w[31:27]); e1[1] = exp6(w[26:21]); e1[2] = exp5(w[20:16]);
    for (int c = 0; c < 3; c++) begin
      if (!three_ok || w[15:0] > w[31:16]) begin
        p2[c] = div3({1'b0, e0[c], 1'b0} + 10'(e1[c]));
        p3[c] = div3(10'(e0[c]) + {1'b0, e1[c], 1'b0});
      end else begin
        h = 9'(e0[c]) + 9'(e1[c]);
        p2[c] = h[8:1];
        p3[c] = 8'd0;
      end
    end
    pal[0] = {8'd255, e0[2], e0[1], e0[0]};
    pal[1] = {8'd255, e1[2], e1[1], e1[0]};
    pal[2] = {8'd255, p2[2], p2[1], p2[0]};
    pal[3] = {((!three_ok || w[15:0] > w[31:16]) ? 8'd255 : 8'd0), p3[2], p3[1], p3[0]};
    return pal;
  endfunction

endpackage

// ===== sv/bcdec_front.sv =====
// bcdec_front: accepts input blocks, resolves the format code and queues them.
// Depends on bcdec_pkg.
module bcdec_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [2:0]          fmt_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [63:0]         lo_i,
  input  logic [63:0]         hi_i,
  output logic                q_valid_o,
  input  logic                q_ready_i,
  output bcdec_pkg::blk_t     q_data_o
);
  import bcdec_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  blk_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  logic            push, pop;
  fmt_e            fmt;

  always_comb begin
    unique case (fmt_i)
      FMT_BC2: fmt = FMT_BC2;
      FMT_BC3: fmt = FMT_BC3;
      FMT_BC4: fmt = FMT_BC4;
      FMT_BC5: fmt = FMT_BC5;
      default: fmt = FMT_BC1;   // undefined codes decode as BC1
    endcase
  end

  assign in_ready_o = cnt_q != (PtrW+1)'(QueueDepth);
  assign q_valid_o  = cnt_q != '0;
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;
  assign q_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= '{fmt: fmt, lo: lo_i, hi: hi_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end
endmodule

// ===== sv/bcdec_back.sv =====
// bcdec_back: builds palettes for one block, then emits its four texel rows.
// Depends on bcdec_pkg.
module bcdec_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  output logic             q_ready_o,
  input  bcdec_pkg::blk_t  q_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       row_o,
  output logic [127:0]     texels_o,
  output logic             last_o
);
  import bcdec_pkg::*;

  pal_t        pal_q;
  logic        pal_v_q;
  logic [1:0]  row_q;
  logic        out_v_q;
  logic [1:0]  orow_q;
  logic [127:0] otex_q;
  logic        pal_done, pal_ld, out_ld;
  logic [63:0] cw;
  logic [3:0][31:0] tex;

  assign cw        = (q_data_i.fmt == FMT_BC1) ? q_data_i.lo : q_data_i.hi;
  assign out_ld    = pal_v_q && (!out_v_q || out_ready_i);
  assign pal_done  = out_ld && row_q == 2'd3;
  assign q_ready_o = !pal_v_q || pal_done;
  assign pal_ld    = q_valid_i && q_ready_o;

  always_comb begin
    logic [4:0] px;
    logic [1:0] k;
    logic [2:0] ai, gi;
    logic [7:0] r, a;
    for (int c = 0; c < 4; c++) begin
      px = {1'b0, row_q, 2'(c)};
      k  = pal_q.cidx[2*px +: 2];
      ai = pal_q.aidx[3*px +: 3];
      gi = pal_q.gidx[3*px +: 3];
      r  = pal_q.apal[ai];
      unique case (pal_q.fmt)
        FMT_BC4: tex[c] = {8'd255, r, r, r};
        FMT_BC5: tex[c] = {8'd255, 8'd255, pal_q.gpal[gi], r};
        default: begin
          a = pal_q.cpal[k][31:24];
          if (pal_q.fmt == FMT_BC2) a = {pal_q.lo[4*px +: 4], pal_q.lo[4*px +: 4]};
          else if (pal_q.fmt == FMT_BC3) a = r;
          tex[c] = {a, pal_q.cpal[k][23:0]};
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pal_ld) begin
      pal_q.cpal <= color_pal(cw[31:0], q_data_i.fmt == FMT_BC1);
      pal_q.apal <= chan_pal(q_data_i.lo[15:0]);
      pal_q.gpal <= chan_pal(q_data_i.hi[15:0]);
      pal_q.aidx <= q_data_i.lo[63:16];
      pal_q.gidx <= q_data_i.hi[63:16];
      pal_q.cidx <= cw[63:32];
      pal_q.lo   <= q_data_i.lo;
      pal_q.fmt  <= q_data_i.fmt;
    end
    if (out_ld) begin
      orow_q <= row_q;
      otex_q <= tex;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_v_q <= 1'b0;
      row_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (pal_ld) pal_v_q <= 1'b1;
      else if (pal_done) pal_v_q <= 1'b0;
      if (out_ld) row_q <= row_q + 1'b1;
      if (out_ld) out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
    end
  end

  assign out_valid_o = out_v_q;
  assign row_o       = orow_q;
  assign texels_o    = otex_q;
  assign last_o      = orow_q == 2'd3;
endmodule

// ===== sv/bc1_to_bc5_block_decoder.sv =====
// BC1..BC5 texture block decoder: one 16-byte block in, four RGBA8 rows out.
// From block accept to row 0 a block passes the queue, the palette register and the output register.
// Throughput: one row per cycle while a block is queued and the output is ready; row rate is the back end's limit.
// A 2-entry queue lets the front accept while the back still emits rows.
// Reset (rst_ni, async low) empties the queue and pipeline; block_format resets to BC1.
module bc1_to_bc5_block_decoder (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration: block_format
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_data_i,
  // input blocks
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [127:0] s_axis_tdata_i,   // [63:0] block_low, [127:64] block_high
  // output rows
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [135:0] m_axis_tdata_o,   // [1:0] row_index, [33:2] texel_zero,
                                         // [65:34] one, [97:66] two, [129:98] three,
                                         // [135:130] zero fill
  output logic         m_axis_tlast_o    // last_row
);
  import bcdec_pkg::*;

  logic [2:0]   fmt_q;
  logic         q_valid, q_ready;
  blk_t         q_data;
  logic [1:0]   row;
  logic [127:0] texels;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fmt_q <= 3'(FMT_BC1);
    else if (cfg_valid_i) fmt_q <= cfg_data_i;
  end

  bcdec_front u_front (
    .clk_i, .rst_ni,
    .fmt_i      (fmt_q),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .lo_i       (s_axis_tdata_i[63:0]),
    .hi_i       (s_axis_tdata_i[127:64]),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_data_o   (q_data)
  );

  bcdec_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_data_i    (q_data),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .row_o       (row),
    .texels_o    (texels),
    .last_o      (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {6'd0, texels, row};

  // tlast marks exactly row three
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (m_axis_tdata_o[1:0] == 2'd3)))
    else $error("tlast mismatch");
  // rows advance in order
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i) ##1 m_axis_tvalid_o |->
      m_axis_tdata_o[1:0] == $past(m_axis_tdata_o[1:0]) + 2'd1)
    else $error("row order");
  // empty queue with a ready back end: the consequent holds for any output valid, as a rise implies it was low
  a_qflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!q_valid && q_ready) |=> !$rose(m_axis_tvalid_o) || $past(m_axis_tvalid_o) == 1'b0)
    else $error("queue flow");
endmodule
